// File: rtl/core/swtm_pkg.sv
// swtm_pkg: shared types and constants of the sliding window traffic meter.
// No dependencies. Used by swtm_ctrl, swtm_dp and sliding_window_traffic_meter_unit.
`timescale 1ns / 1ps
`default_nettype none
package swtm_pkg;

	localparam int unsigned TimeW  = 48;
	localparam int unsigned SumW   = 40;
	localparam int unsigned LatW   = 64;
	localparam int unsigned DivCnt = 64;
	localparam logic [47:0] WinReset = 48'd1000000;
	localparam logic [39:0] Max40 = {40{1'b1}};
	localparam logic [31:0] Max32 = {32{1'b1}};
	localparam logic [15:0] Max16 = {16{1'b1}};

	typedef enum logic [2:0] {
		FN_PKT    = 3'd0,
		FN_TXN    = 3'd1,
		FN_OPEN   = 3'd2,
		FN_CLOSE  = 3'd3,
		FN_SNAP   = 3'd4,
		FN_CLEAR  = 3'd5
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WAIT,
		ST_EXEC,
		ST_PWAIT,
		ST_PCHK,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load_item;
		logic push_pkt;
		logic push_txn;
		logic stream_inc;
		logic stream_dec;
		logic prune_now;
		logic prune_last;
		logic clear;
		logic pop_pkt;
		logic pop_txn;
		logic div_start;
		logic div_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic [2:0] func;
		logic       complete;
		logic       has_time;
		logic       last_valid;
		logic       pkt_old;
		logic       txn_old;
		logic       div_busy;
		logic       out_free;
	} sts_t;

endpackage
`default_nettype wire

// File: rtl/core/sliding_window_traffic_meter_unit.sv
// Channel    Dir  Handshake             Payload
// request    in   in_valid / in_ready   func byte_count event_time latency_us complete has_time
// result     out  out_valid / out_ready window_bytes .. evicted
// config     in   cfg_wen               cfg_wdata (window length)
// One request at a time. Packets, pruning snapshots and complete transactions pop the aged
// FIFO heads; a complete transaction then runs the bit-serial latency divider.
// Pops are the aged FIFO head entries; each needs a registered head read.
// A finished result sits in the output register; the next request is taken meanwhile,
// and its result waits while the previous one is unread.
// Reset arst_n async active low; FIFO storage needs no clearing.
// Top level of the sliding window traffic meter. Depends on swtm_pkg, swtm_ctrl, swtm_dp.
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_traffic_meter_unit #(
	parameter int unsigned PACKET_DEPTH = 1024,
	parameter int unsigned TXN_DEPTH    = 1024
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_wen,
	input  wire logic [47:0]   cfg_wdata,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [2:0]    func,
	input  wire logic [15:0]   byte_count,
	input  wire logic [47:0]   event_time,
	input  wire logic [31:0]   latency_us,
	input  wire logic          complete,
	input  wire logic          has_time,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [39:0]        window_bytes,
	output logic [10:0]        window_transactions,
	output logic [39:0]        request_count,
	output logic [39:0]        packet_count,
	output logic [15:0]        open_streams,
	output logic [31:0]        avg_latency,
	output logic               evicted
);

	swtm_pkg::cmd_t cmd;
	swtm_pkg::sts_t sts;

	swtm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	swtm_dp #(
		.PACKET_DEPTH (PACKET_DEPTH),
		.TXN_DEPTH    (TXN_DEPTH)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_wen             (cfg_wen),
		.cfg_wdata           (cfg_wdata),
		.func                (func),
		.byte_count          (byte_count),
		.event_time          (event_time),
		.latency_us          (latency_us),
		.complete            (complete),
		.has_time            (has_time),
		.cmd                 (cmd),
		.sts                 (sts),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.window_bytes        (window_bytes),
		.window_transactions (window_transactions),
		.request_count       (request_count),
		.packet_count        (packet_count),
		.open_streams        (open_streams),
		.avg_latency         (avg_latency),
		.evicted             (evicted)
	);

endmodule
`default_nettype wire

// File: rtl/core/swtm_ctrl.sv
// swtm_ctrl: sequencer of the traffic meter; issues datapath commands per request.
// Depends on swtm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module swtm_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  swtm_pkg::sts_t     sts,
	output swtm_pkg::cmd_t     cmd
);

	swtm_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swtm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			swtm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d = swtm_pkg::ST_WAIT;
				end
			end
			swtm_pkg::ST_WAIT: begin
				state_d = swtm_pkg::ST_EXEC;
			end
			swtm_pkg::ST_EXEC: begin
				state_d = swtm_pkg::ST_DONE;
				case (swtm_pkg::func_t'(sts.func))
					swtm_pkg::FN_PKT: begin
						cmd.push_pkt = 1'b1;
						state_d = swtm_pkg::ST_PWAIT;
					end
					swtm_pkg::FN_TXN: begin
						if (sts.complete) begin
							cmd.push_txn = 1'b1;
							state_d = swtm_pkg::ST_PWAIT;
						end
					end
					swtm_pkg::FN_OPEN:  cmd.stream_inc = 1'b1;
					swtm_pkg::FN_CLOSE: cmd.stream_dec = 1'b1;
					swtm_pkg::FN_SNAP: begin
						if (sts.has_time) begin
							cmd.prune_now = 1'b1;
							state_d = swtm_pkg::ST_PWAIT;
						end else if (sts.last_valid) begin
							cmd.prune_last = 1'b1;
							state_d = swtm_pkg::ST_PWAIT;
						end
					end
					swtm_pkg::FN_CLEAR: cmd.clear = 1'b1;
					default: ;
				endcase
			end
			swtm_pkg::ST_PWAIT: begin
				state_d = swtm_pkg::ST_PCHK;
			end
			swtm_pkg::ST_PCHK: begin
				if (sts.pkt_old) begin
					cmd.pop_pkt = 1'b1;
					state_d = swtm_pkg::ST_PWAIT;
				end else if (sts.txn_old) begin
					cmd.pop_txn = 1'b1;
					state_d = swtm_pkg::ST_PWAIT;
				end else if (swtm_pkg::func_t'(sts.func) == swtm_pkg::FN_TXN) begin
					cmd.div_start = 1'b1;
					state_d = swtm_pkg::ST_DIV;
				end else begin
					state_d = swtm_pkg::ST_DONE;
				end
			end
			swtm_pkg::ST_DIV: begin
				if (sts.div_busy) begin
					cmd.div_step = 1'b1;
				end else begin
					state_d = swtm_pkg::ST_DONE;
				end
			end
			swtm_pkg::ST_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d = swtm_pkg::ST_IDLE;
				end
			end
			default: state_d = swtm_pkg::ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/core/swtm_dp.sv
// swtm_dp: FIFOs, window sums, totals, latency divider and output register.
// Depends on swtm_pkg; driven by swtm_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module swtm_dp #(
	parameter int unsigned PACKET_DEPTH = 1024,
	parameter int unsigned TXN_DEPTH    = 1024
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_wen,
	input  wire logic [47:0]   cfg_wdata,
	input  wire logic [2:0]    func,
	input  wire logic [15:0]   byte_count,
	input  wire logic [47:0]   event_time,
	input  wire logic [31:0]   latency_us,
	input  wire logic          complete,
	input  wire logic          has_time,
	input  swtm_pkg::cmd_t     cmd,
	output swtm_pkg::sts_t     sts,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [39:0]        window_bytes,
	output logic [10:0]        window_transactions,
	output logic [39:0]        request_count,
	output logic [39:0]        packet_count,
	output logic [15:0]        open_streams,
	output logic [31:0]        avg_latency,
	output logic               evicted
);

	localparam int unsigned PAW = (PACKET_DEPTH > 1) ? $clog2(PACKET_DEPTH) : 1;
	localparam int unsigned PCW = $clog2(PACKET_DEPTH + 1);
	localparam int unsigned TAW = (TXN_DEPTH > 1) ? $clog2(TXN_DEPTH) : 1;
	localparam int unsigned TCW = $clog2(TXN_DEPTH + 1);
	localparam logic [PCW-1:0] PFull = PCW'(PACKET_DEPTH);
	localparam logic [TCW-1:0] TFull = TCW'(TXN_DEPTH);

	logic [47:0] pkt_time_mem [PACKET_DEPTH];
	logic [15:0] pkt_size_mem [PACKET_DEPTH];
	logic [47:0] txn_time_mem [TXN_DEPTH];

	logic [47:0]    window_q;
	logic [2:0]     func_q;
	logic [15:0]    bytes_q;
	logic [47:0]    time_q;
	logic [31:0]    lat_q;
	logic           complete_q, has_time_q;
	logic [PAW-1:0] pkt_head_q;
	logic [PCW-1:0] pkt_cnt_q;
	logic [TAW-1:0] txn_head_q;
	logic [TCW-1:0] txn_cnt_q;
	logic [47:0]    pkt_rd_time_q, txn_rd_time_q;
	logic [15:0]    pkt_rd_size_q;
	logic [39:0]    byte_sum_q, req_total_q, pkt_total_q;
	logic [63:0]    lat_total_q;
	logic [15:0]    streams_q;
	logic [47:0]    last_time_q, prune_time_q;
	logic           last_valid_q, evict_q;
	logic [39:0]    div_rem_q;
	logic [63:0]    div_quo_q;
	logic [6:0]     div_cnt_q;
	logic           out_valid_q;

	logic [PAW:0]   pkt_tail_sum, pkt_head_inc;
	logic [TAW:0]   txn_tail_sum, txn_head_inc;
	logic [PAW-1:0] pkt_tail, pkt_head_nx;
	logic [TAW-1:0] txn_tail, txn_head_nx;
	logic           pkt_full, txn_full, pkt_rd_old_now, txn_rd_old_now;
	logic [39:0]    sum_pop;
	logic [64:0]    lat_add;
	logic [40:0]    div_trial;
	logic [31:0]    avg_sat;
	logic [31:0]    txn_cnt32;

	always_comb begin
		pkt_tail_sum = {1'b0, pkt_head_q} + (PAW+1)'(pkt_cnt_q);
		pkt_tail = (pkt_tail_sum >= (PAW+1)'(PACKET_DEPTH)) ?
			PAW'(pkt_tail_sum - (PAW+1)'(PACKET_DEPTH)) : pkt_tail_sum[PAW-1:0];
		pkt_head_inc = {1'b0, pkt_head_q} + (PAW+1)'(1);
		pkt_head_nx = (pkt_head_inc == (PAW+1)'(PACKET_DEPTH)) ? '0 : pkt_head_inc[PAW-1:0];
		txn_tail_sum = {1'b0, txn_head_q} + (TAW+1)'(txn_cnt_q);
		txn_tail = (txn_tail_sum >= (TAW+1)'(TXN_DEPTH)) ?
			TAW'(txn_tail_sum - (TAW+1)'(TXN_DEPTH)) : txn_tail_sum[TAW-1:0];
		txn_head_inc = {1'b0, txn_head_q} + (TAW+1)'(1);
		txn_head_nx = (txn_head_inc == (TAW+1)'(TXN_DEPTH)) ? '0 : txn_head_inc[TAW-1:0];
		pkt_full = (pkt_cnt_q == PFull);
		txn_full = (txn_cnt_q == TFull);
		pkt_rd_old_now = ({1'b0, pkt_rd_time_q} + {1'b0, window_q}) < {1'b0, time_q};
		txn_rd_old_now = ({1'b0, txn_rd_time_q} + {1'b0, window_q}) < {1'b0, time_q};
		sum_pop = (byte_sum_q >= {24'd0, pkt_rd_size_q}) ?
			byte_sum_q - {24'd0, pkt_rd_size_q} : '0;
		lat_add = {1'b0, lat_total_q} + {33'd0, lat_q};
		div_trial = {div_rem_q, div_quo_q[63]};
		avg_sat = (div_quo_q[63:32] != '0) ? swtm_pkg::Max32 : div_quo_q[31:0];
		txn_cnt32 = 32'(txn_cnt_q);
	end

	always_comb begin
		sts.func       = func_q;
		sts.complete   = complete_q;
		sts.has_time   = has_time_q;
		sts.last_valid = last_valid_q;
		sts.pkt_old    = (pkt_cnt_q != '0) &&
			(({1'b0, pkt_rd_time_q} + {1'b0, window_q}) < {1'b0, prune_time_q});
		sts.txn_old    = (txn_cnt_q != '0) &&
			(({1'b0, txn_rd_time_q} + {1'b0, window_q}) < {1'b0, prune_time_q});
		sts.div_busy   = (div_cnt_q != '0);
		sts.out_free   = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		pkt_rd_time_q <= pkt_time_mem[pkt_head_q];
		pkt_rd_size_q <= pkt_size_mem[pkt_head_q];
		txn_rd_time_q <= txn_time_mem[txn_head_q];
		if (cmd.push_pkt) begin
			pkt_time_mem[pkt_tail] <= time_q;
			pkt_size_mem[pkt_tail] <= bytes_q;
		end
		if (cmd.push_txn) begin
			txn_time_mem[txn_tail] <= time_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			func_q     <= func;
			bytes_q    <= byte_count;
			time_q     <= event_time;
			lat_q      <= latency_us;
			complete_q <= complete;
			has_time_q <= has_time;
		end
		if (cmd.push_pkt || cmd.push_txn || cmd.prune_now) begin
			prune_time_q <= time_q;
		end else if (cmd.prune_last) begin
			prune_time_q <= last_time_q;
		end
		if (cmd.load_out) begin
			window_bytes        <= byte_sum_q;
			window_transactions <= txn_cnt32[10:0];
			request_count       <= req_total_q;
			packet_count        <= pkt_total_q;
			open_streams        <= streams_q;
			avg_latency         <= avg_sat;
			evicted             <= evict_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q     <= swtm_pkg::WinReset;
			pkt_head_q   <= '0;
			pkt_cnt_q    <= '0;
			txn_head_q   <= '0;
			txn_cnt_q    <= '0;
			byte_sum_q   <= '0;
			req_total_q  <= '0;
			pkt_total_q  <= '0;
			lat_total_q  <= '0;
			streams_q    <= '0;
			last_time_q  <= '0;
			last_valid_q <= 1'b0;
			evict_q      <= 1'b0;
			div_rem_q    <= '0;
			div_quo_q    <= '0;
			div_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wen) begin
				window_q <= cfg_wdata;
			end
			if (cmd.load_item) begin
				evict_q <= 1'b0;
			end
			if (cmd.push_pkt) begin
				if (pkt_full) begin
					evict_q    <= !pkt_rd_old_now;
					pkt_head_q <= pkt_head_nx;
					byte_sum_q <= sum_pop + {24'd0, bytes_q};
				end else begin
					pkt_cnt_q  <= pkt_cnt_q + PCW'(1);
					byte_sum_q <= byte_sum_q + {24'd0, bytes_q};
				end
				if (pkt_total_q != swtm_pkg::Max40) begin
					pkt_total_q <= pkt_total_q + 40'd1;
				end
				last_time_q  <= time_q;
				last_valid_q <= 1'b1;
			end
			if (cmd.push_txn) begin
				if (txn_full) begin
					evict_q    <= !txn_rd_old_now;
					txn_head_q <= txn_head_nx;
				end else begin
					txn_cnt_q <= txn_cnt_q + TCW'(1);
				end
				lat_total_q <= lat_add[64] ? {64{1'b1}} : lat_add[63:0];
				if (req_total_q != swtm_pkg::Max40) begin
					req_total_q <= req_total_q + 40'd1;
				end
				last_time_q  <= time_q;
				last_valid_q <= 1'b1;
			end
			if (cmd.stream_inc && streams_q != swtm_pkg::Max16) begin
				streams_q <= streams_q + 16'd1;
			end
			if (cmd.stream_dec && streams_q != '0) begin
				streams_q <= streams_q - 16'd1;
			end
			if (cmd.pop_pkt) begin
				byte_sum_q <= sum_pop;
				pkt_head_q <= pkt_head_nx;
				pkt_cnt_q  <= pkt_cnt_q - PCW'(1);
			end
			if (cmd.pop_txn) begin
				txn_head_q <= txn_head_nx;
				txn_cnt_q  <= txn_cnt_q - TCW'(1);
			end
			if (cmd.div_start) begin
				div_rem_q <= '0;
				div_quo_q <= lat_total_q;
				div_cnt_q <= 7'(swtm_pkg::DivCnt);
			end else if (cmd.div_step) begin
				if (div_trial >= {1'b0, req_total_q}) begin
					div_rem_q <= 40'(div_trial - {1'b0, req_total_q});
					div_quo_q <= {div_quo_q[62:0], 1'b1};
				end else begin
					div_rem_q <= div_trial[39:0];
					div_quo_q <= {div_quo_q[62:0], 1'b0};
				end
				div_cnt_q <= div_cnt_q - 7'd1;
			end
			if (cmd.clear) begin
				pkt_head_q   <= '0;
				pkt_cnt_q    <= '0;
				txn_head_q   <= '0;
				txn_cnt_q    <= '0;
				byte_sum_q   <= '0;
				req_total_q  <= '0;
				pkt_total_q  <= '0;
				lat_total_q  <= '0;
				streams_q    <= '0;
				last_time_q  <= '0;
				last_valid_q <= 1'b0;
				div_quo_q    <= '0;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTH
	a_pkt_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_cnt_q <= PFull) else $error("packet fifo count above depth");
	a_txn_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		txn_cnt_q <= TFull) else $error("transaction fifo count above depth");
	a_out_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready)) else $error("result overwritten");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (byte_sum_q == '0 && txn_cnt_q == '0 && req_total_q == '0))
		else $error("clear left state");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> div_cnt_q == '0) else $error("result before divide done");
`endif

endmodule
`default_nettype wire

// File: sim/swtm_checker.sv
// swtm_checker: watches the request, result and config channels of the traffic meter,
// predicts each result and compares it field by field. Depends on swtm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module swtm_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wen,
	input  wire logic [47:0] cfg_wdata,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [2:0]  func,
	input  wire logic [15:0] byte_count,
	input  wire logic [47:0] event_time,
	input  wire logic [31:0] latency_us,
	input  wire logic        complete,
	input  wire logic        has_time,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [39:0] window_bytes,
	input  wire logic [10:0] window_transactions,
	input  wire logic [39:0] request_count,
	input  wire logic [39:0] packet_count,
	input  wire logic [15:0] open_streams,
	input  wire logic [31:0] avg_latency,
	input  wire logic        evicted,
	output int               fail_count,
	output int               pending
);
	localparam int unsigned Depth = 1024;
	localparam int unsigned SlotCount = 8;

	typedef struct packed {
		logic [39:0] wbytes;
		logic [10:0] wtxn;
		logic [39:0] reqs;
		logic [39:0] pkts;
		logic [15:0] streams;
		logic [31:0] avg;
		logic        evict;
	} meter_res_t;

	meter_res_t      exp_slots[SlotCount];
	int unsigned     wr_ptr, rd_ptr;

	logic [47:0]     window_len;
	logic [47:0]     pkt_time[Depth];
	logic [15:0]     pkt_size[Depth];
	logic [47:0]     txn_time[Depth];
	int unsigned     pkt_head, pkt_fill, txn_head, txn_fill;
	longint unsigned byte_sum, lat_sum, req_total, pkt_total;
	int unsigned     stream_cnt;
	logic [47:0]     last_stamp;
	bit              last_ok;

	function automatic bit aged(logic [47:0] ts, logic [47:0] now);
		longint unsigned a;
		a = longint'(ts) + longint'(window_len);
		return a < longint'(now);
	endfunction

	function automatic void drop_pkt();
		byte_sum = (byte_sum >= pkt_size[pkt_head]) ? byte_sum - pkt_size[pkt_head] : 0;
		pkt_head = (pkt_head + 1) % Depth;
		pkt_fill--;
	endfunction

	function automatic void drop_txn();
		txn_head = (txn_head + 1) % Depth;
		txn_fill--;
	endfunction

	function automatic void age_out(logic [47:0] now);
		while (pkt_fill > 0 && aged(pkt_time[pkt_head], now))
			drop_pkt();
		while (txn_fill > 0 && aged(txn_time[txn_head], now))
			drop_txn();
	endfunction

	function automatic void wipe();
		pkt_head = 0; pkt_fill = 0; txn_head = 0; txn_fill = 0;
		byte_sum = 0; lat_sum = 0; req_total = 0; pkt_total = 0;
		stream_cnt = 0; last_stamp = '0; last_ok = 0;
	endfunction

	function automatic meter_res_t meter_predict(logic [2:0] fn, logic [15:0] nbytes,
			logic [47:0] now, logic [31:0] lat, logic done, logic timed);
		meter_res_t      r;
		bit              ev;
		longint unsigned avg;
		ev = 0;
		avg = 0;
		case (swtm_pkg::func_t'(fn))
			swtm_pkg::FN_PKT: begin
				if (pkt_fill == Depth) begin
					if (!aged(pkt_time[pkt_head], now))
						ev = 1;
					drop_pkt();
				end
				pkt_time[(pkt_head + pkt_fill) % Depth] = now;
				pkt_size[(pkt_head + pkt_fill) % Depth] = nbytes;
				pkt_fill++;
				byte_sum += nbytes;
				if (pkt_total < 64'(swtm_pkg::Max40))
					pkt_total++;
				last_stamp = now;
				last_ok = 1;
				age_out(now);
			end
			swtm_pkg::FN_TXN: begin
				if (done) begin
					if (lat_sum > 64'hFFFF_FFFF_FFFF_FFFF - 64'(lat))
						lat_sum = 64'hFFFF_FFFF_FFFF_FFFF;
					else
						lat_sum += 64'(lat);
					if (req_total < 64'(swtm_pkg::Max40))
						req_total++;
					if (txn_fill == Depth) begin
						if (!aged(txn_time[txn_head], now))
							ev = 1;
						drop_txn();
					end
					txn_time[(txn_head + txn_fill) % Depth] = now;
					txn_fill++;
					last_stamp = now;
					last_ok = 1;
					age_out(now);
				end
			end
			swtm_pkg::FN_OPEN: begin
				if (stream_cnt < 32'(swtm_pkg::Max16))
					stream_cnt++;
			end
			swtm_pkg::FN_CLOSE: begin
				if (stream_cnt > 0)
					stream_cnt--;
			end
			swtm_pkg::FN_SNAP: begin
				if (timed)
					age_out(now);
				else if (last_ok)
					age_out(last_stamp);
			end
			swtm_pkg::FN_CLEAR: begin
				wipe();
			end
			default: ;
		endcase
		if (req_total > 0) begin
			avg = lat_sum / req_total;
			if (avg > 64'(swtm_pkg::Max32))
				avg = 64'(swtm_pkg::Max32);
		end
		r.wbytes  = byte_sum[39:0];
		r.wtxn    = txn_fill[10:0];
		r.reqs    = req_total[39:0];
		r.pkts    = pkt_total[39:0];
		r.streams = stream_cnt[15:0];
		r.avg     = avg[31:0];
		r.evict   = ev;
		return r;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		meter_res_t e;
		if (!arst_n) begin
			window_len = swtm_pkg::WinReset;
			wipe();
			wr_ptr = 0;
			rd_ptr = 0;
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_wen)
				window_len = cfg_wdata;
			if (out_valid && out_ready) begin
				if (pending == 0) begin
					$display("%0t: result with no request outstanding", $realtime);
					fail_count++;
				end else begin
					e = exp_slots[rd_ptr];
					rd_ptr = (rd_ptr + 1) % SlotCount;
					pending--;
					if (window_bytes !== e.wbytes)
						report("window_bytes", 64'(window_bytes), 64'(e.wbytes));
					if (window_transactions !== e.wtxn)
						report("window_transactions", 64'(window_transactions),
							64'(e.wtxn));
					if (request_count !== e.reqs)
						report("request_count", 64'(request_count), 64'(e.reqs));
					if (packet_count !== e.pkts)
						report("packet_count", 64'(packet_count), 64'(e.pkts));
					if (open_streams !== e.streams)
						report("open_streams", 64'(open_streams), 64'(e.streams));
					if (avg_latency !== e.avg)
						report("avg_latency", 64'(avg_latency), 64'(e.avg));
					if (evicted !== e.evict)
						report("evicted", 64'(evicted), 64'(e.evict));
				end
			end
			if (in_valid && in_ready) begin
				if (pending >= int'(SlotCount)) begin
					$display("%0t: too many requests outstanding", $realtime);
					fail_count++;
				end else begin
					exp_slots[wr_ptr] = meter_predict(func, byte_count, event_time,
						latency_us, complete, has_time);
					wr_ptr = (wr_ptr + 1) % SlotCount;
					pending++;
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: sim/tb_sliding_window_traffic_meter_unit.sv
// tb_sliding_window_traffic_meter_unit: request stimulus, receiver stalls, window
// settings and verdict for the traffic meter. Depends on swtm_pkg and swtm_checker.
`timescale 1ns / 1ps
`default_nettype none
module tb_sliding_window_traffic_meter_unit;

	localparam logic [2:0] FnSpare6 = 3'd6;
	localparam logic [2:0] FnSpare7 = 3'd7;
	localparam int unsigned StallLimit = 20000;

	typedef struct {
		logic [2:0]  f;
		logic [15:0] b;
		logic [47:0] t;
		logic [31:0] l;
		logic        c;
		logic        h;
	} meter_req_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_wen = 0;
	logic [47:0] cfg_wdata = '0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [2:0]  func = '0;
	logic [15:0] byte_count = '0;
	logic [47:0] event_time = '0;
	logic [31:0] latency_us = '0;
	logic        complete = 0;
	logic        has_time = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [39:0] window_bytes;
	logic [10:0] window_transactions;
	logic [39:0] request_count;
	logic [39:0] packet_count;
	logic [15:0] open_streams;
	logic [31:0] avg_latency;
	logic        evicted;
	int          fail_count;
	int          pending;

	logic [47:0] clock_now = '0;
	int          burst_left = 1;
	int unsigned quiet_cycles = 0;
	int unsigned rx_cycle = 0;
	int          rx_hold = 0;

	always #5 clk = ~clk;

	sliding_window_traffic_meter_unit i_dut (
		.clk, .arst_n, .cfg_wen, .cfg_wdata, .in_valid, .in_ready,
		.func, .byte_count, .event_time, .latency_us, .complete, .has_time,
		.out_valid, .out_ready, .window_bytes, .window_transactions,
		.request_count, .packet_count, .open_streams, .avg_latency, .evicted
	);

	swtm_checker i_checker (.*);

	// receiver stall pattern: four modes in rotation
	always @(posedge clk) begin
		rx_cycle <= rx_cycle + 1;
		case ((rx_cycle / 300) % 4)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 9) < 7);
			2: begin
				if (rx_hold > 0)
					rx_hold <= rx_hold - 1;
				else begin
					rx_hold <= $urandom_range(1, 20);
					out_ready <= ~out_ready;
				end
			end
			default: out_ready <= (rx_cycle[2:0] != 3'd0);
		endcase
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > StallLimit) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send(meter_req_t r);
		in_valid   <= 1'b1;
		func       <= r.f;
		byte_count <= r.b;
		event_time <= r.t;
		latency_us <= r.l;
		complete   <= r.c;
		has_time   <= r.h;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// bursts of requests separated by random gaps
	task automatic put(meter_req_t r, bit gaps);
		send(r);
		if (gaps && --burst_left <= 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150) :
				$urandom_range(1, 30);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_window(logic [47:0] w);
		drain();
		cfg_wen   <= 1'b1;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(posedge clk);
	endtask

	function automatic meter_req_t mk(logic [2:0] f, logic [15:0] b, logic [47:0] t,
			logic [31:0] l, logic c, logic h);
		meter_req_t r;
		r.f = f; r.b = b; r.t = t; r.l = l; r.c = c; r.h = h;
		return r;
	endfunction

	function automatic logic [47:0] rand48();
		return {16'($urandom), $urandom};
	endfunction

	function automatic logic [47:0] advance(int unsigned max_step);
		int unsigned k;
		k = $urandom_range(0, 199);
		if (k == 0)
			clock_now = rand48();
		else if (k < 4)
			clock_now = clock_now - 48'($urandom_range(0, max_step));
		else
			clock_now = clock_now + 48'($urandom_range(0, max_step));
		return clock_now;
	endfunction

	function automatic meter_req_t rand_req(int unsigned max_step);
		int unsigned k;
		logic [31:0] lat;
		k = $urandom_range(0, 99);
		lat = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 5000));
		if (k < 40)
			return mk(swtm_pkg::FN_PKT, 16'($urandom), advance(max_step), $urandom,
				1'($urandom), 1'($urandom));
		if (k < 66)
			return mk(swtm_pkg::FN_TXN, 16'($urandom), advance(max_step), lat,
				1'($urandom_range(0, 6) != 0), 1'($urandom));
		if (k < 74)
			return mk(swtm_pkg::FN_OPEN, 16'($urandom), advance(max_step), $urandom,
				1'($urandom), 1'($urandom));
		if (k < 82)
			return mk(swtm_pkg::FN_CLOSE, 16'($urandom), advance(max_step), $urandom,
				1'($urandom), 1'($urandom));
		if (k < 96)
			return mk(swtm_pkg::FN_SNAP, 16'($urandom), advance(max_step), $urandom,
				1'($urandom), 1'($urandom));
		if (k < 98)
			return mk(swtm_pkg::FN_CLEAR, 16'($urandom), advance(max_step), $urandom,
				1'($urandom), 1'($urandom));
		return mk(($urandom_range(0, 1) != 0) ? FnSpare6 : FnSpare7, 16'($urandom),
			advance(max_step), $urandom, 1'($urandom), 1'($urandom));
	endfunction

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		put(mk(swtm_pkg::FN_SNAP, 16'd0, 48'd0, 32'd0, 1'b0, 1'b0), 0);
		put(mk(swtm_pkg::FN_CLOSE, 16'd0, 48'd0, 32'd0, 1'b0, 1'b0), 0);
		put(mk(swtm_pkg::FN_TXN, 16'd0, 48'd5, 32'd0, 1'b0, 1'b1), 0);
		put(mk(swtm_pkg::FN_PKT, 16'd0, 48'd10, 32'd0, 1'b0, 1'b0), 0);
		put(mk(swtm_pkg::FN_PKT, 16'hFFFF, 48'd20, 32'd0, 1'b0, 1'b0), 0);
		put(mk(swtm_pkg::FN_TXN, 16'd0, 48'd30, 32'd0, 1'b1, 1'b0), 0);
		put(mk(swtm_pkg::FN_TXN, 16'd0, 48'd40, 32'hFFFF_FFFF, 1'b1, 1'b0), 0);
		put(mk(swtm_pkg::FN_OPEN, 16'd0, 48'd40, 32'd0, 1'b0, 1'b0), 0);
		put(mk(swtm_pkg::FN_OPEN, 16'd0, 48'd40, 32'd0, 1'b0, 1'b0), 0);
		put(mk(swtm_pkg::FN_CLOSE, 16'd0, 48'd40, 32'd0, 1'b0, 1'b0), 0);
		put(mk(swtm_pkg::FN_SNAP, 16'd0, 48'd0, 32'd0, 1'b0, 1'b0), 0);
		put(mk(swtm_pkg::FN_SNAP, 16'd0, 48'd1000020, 32'd0, 1'b0, 1'b1), 0);
		put(mk(swtm_pkg::FN_SNAP, 16'd0, 48'd2000000, 32'd0, 1'b0, 1'b1), 0);
		put(mk(FnSpare6, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1), 0);
		put(mk(FnSpare7, 16'd0, 48'd0, 32'd0, 1'b0, 1'b0), 0);
		put(mk(swtm_pkg::FN_PKT, 16'd100, 48'hFFFF_FFFF_FFFF, 32'd0, 1'b0, 1'b0), 0);
		put(mk(swtm_pkg::FN_PKT, 16'd200, 48'd3, 32'd0, 1'b0, 1'b0), 0);
		put(mk(swtm_pkg::FN_TXN, 16'd0, 48'd2, 32'd77, 1'b1, 1'b0), 0);
		put(mk(swtm_pkg::FN_SNAP, 16'd0, 48'd0, 32'd0, 1'b0, 1'b0), 0);
		put(mk(swtm_pkg::FN_CLEAR, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1),
			0);
		put(mk(swtm_pkg::FN_SNAP, 16'd0, 48'd50, 32'd0, 1'b0, 1'b0), 0);

		// shortest window
		set_window(48'd1);
		clock_now = '0;
		repeat (120) put(rand_req(3), 1);

		// longest window: fill the packet FIFO past capacity, all heads live
		set_window(48'hFFFF_FFFF_FFFF);
		put(mk(swtm_pkg::FN_CLEAR, 16'd0, 48'd0, 32'd0, 1'b0, 1'b0), 1);
		clock_now = 48'd1000;
		repeat (1030) put(mk(swtm_pkg::FN_PKT, 16'($urandom), advance(50), 32'd0,
			1'b0, 1'b0), 1);
		repeat (20) put(mk(swtm_pkg::FN_TXN, 16'd0, advance(50),
			32'($urandom_range(0, 100000)), 1'b1, 1'b0), 1);

		// tight window on a full FIFO: pushes drop aged heads, then long prunes
		set_window(48'd3000);
		repeat (5) put(mk(swtm_pkg::FN_PKT, 16'($urandom), advance(6), 32'd0,
			1'b0, 1'b0), 1);
		repeat (150) put(rand_req(40), 1);

		set_window(48'd500);
		repeat (200) put(rand_req(60), 1);

		set_window(rand48());
		repeat (100) put(rand_req(32'hFFFF_FFFF), 1);

		drain();
		repeat (100) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
`default_nettype wire
